@@ design/lbbc_pkg.sv @@
package lbbc_pkg;

  // Store geometry. The count width is fixed by the 13-bit fields of the words.
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 13;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_WRITE   = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_BACK    = 3'd2;
  localparam logic [2:0] KIND_COMPACT = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             done_res;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] read_offset;
  } out_t;

endpackage

@@ design/lbbc_ram.sv @@
module lbbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/linear_byte_buffer_compacting.sv @@
// Linear byte buffer with push-back and compaction.
//
// The input channel (in_valid/in_ready/in_data) takes one operation word per
// item: write, read, push back, compact or clear. The output channel
// (out_valid/out_ready/out_data) returns exactly one result word per item with
// the byte read, a done flag, the fill, the free space after the write index
// and the read offset. The capacity register is written through cfg_we and
// cfg_data; the user must write it only while the block is idle, as the block itself does not enforce this.
//
// Items are handled one at a time. Write, push back, clear and unused codes
// pass from the idle state through the finish state to the loaded result; a
// read also passes through the read state, because the byte comes back from
// the single-port-read RAM through its registered read. Compaction moves one
// byte per cycle through the RAM read and write ports until every unread byte has moved.
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; if the receiver stalls, the next result holds
// in the finish state until the output register frees up.
// Reset empties the buffer, sets capacity to the full depth and needs no
// clearing pass: the storage is only read where it has been written.
module linear_byte_buffer_compacting
  import lbbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t           state, state_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic [CNT_W-1:0] wr_idx, wr_idx_next;
  logic [CNT_W-1:0] move_counter, move_counter_next;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic             wr_pend, wr_pend_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic [7:0]       res_data, res_data_next;
  logic             res_done, res_done_next;
  logic             out_valid_next;
  logic [CNT_W-1:0] capacity;

  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] rd_dec;
  logic [CNT_W-1:0] src_idx;
  logic             load_out;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  lbbc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A zero capacity behaves as one byte, anything above the depth as the depth.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (capacity > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = capacity;
    end
  end

  assign fill    = wr_idx - rd_idx;
  assign room    = (wr_idx >= cap_eff) ? '0 : cap_eff - wr_idx;
  assign rd_dec  = rd_idx - CNT_W'(1);
  assign src_idx = rd_idx + rd_cnt;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rd_idx       <= '0;
      wr_idx       <= '0;
      move_counter <= '0;
      rd_cnt       <= '0;
      wr_pend      <= 1'b0;
      out_valid    <= 1'b0;
      capacity     <= DEPTH_C;
    end else begin
      state        <= state_next;
      rd_idx       <= rd_idx_next;
      wr_idx       <= wr_idx_next;
      move_counter <= move_counter_next;
      rd_cnt       <= rd_cnt_next;
      wr_pend      <= wr_pend_next;
      out_valid    <= out_valid_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    wr_addr  <= wr_addr_next;
    res_data <= res_data_next;
    res_done <= res_done_next;
    if (load_out) begin
      out_data.data_out    <= res_data;
      out_data.done_res    <= res_done;
      out_data.fill_count  <= fill;
      out_data.free_count  <= room;
      out_data.read_offset <= rd_idx;
    end
  end

  always_comb begin
    state_next        = state;
    rd_idx_next       = rd_idx;
    wr_idx_next       = wr_idx;
    move_counter_next = move_counter;
    rd_cnt_next       = rd_cnt;
    wr_pend_next      = 1'b0;
    wr_addr_next      = wr_addr;
    res_data_next     = res_data;
    res_done_next     = res_done;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = '0;
    ram_re            = 1'b0;
    ram_raddr         = '0;
    load_out          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_data_next = '0;
          res_done_next = 1'b0;
          state_next    = ST_FINISH;
          unique case (in_data.kind)
            KIND_WRITE: begin
              if (wr_idx < cap_eff) begin
                ram_we        = 1'b1;
                ram_waddr     = wr_idx[ADDR_W-1:0];
                ram_wdata     = in_data.data_in;
                wr_idx_next   = wr_idx + CNT_W'(1);
                res_done_next = 1'b1;
              end
            end
            KIND_READ: begin
              if (fill != '0) begin
                // The byte arrives from the RAM in the next cycle.
                ram_re        = 1'b1;
                ram_raddr     = rd_idx[ADDR_W-1:0];
                res_done_next = 1'b1;
                state_next    = ST_READ;
              end
              if (fill > CNT_W'(1)) begin
                rd_idx_next = rd_idx + CNT_W'(1);
              end else begin
                // Taking the last byte, or reading an empty store, rewinds it.
                rd_idx_next = '0;
                wr_idx_next = '0;
              end
            end
            KIND_BACK: begin
              if (rd_idx != '0) begin
                ram_we        = 1'b1;
                ram_waddr     = rd_dec[ADDR_W-1:0];
                ram_wdata     = in_data.data_in;
                rd_idx_next   = rd_dec;
                res_done_next = 1'b1;
              end
            end
            KIND_COMPACT: begin
              move_counter_next = fill;
              rd_cnt_next       = '0;
              res_done_next     = 1'b1;
              if (fill != '0) begin
                state_next = ST_COPY;
              end else begin
                rd_idx_next = '0;
                wr_idx_next = '0;
              end
            end
            KIND_CLEAR: begin
              rd_idx_next   = '0;
              wr_idx_next   = '0;
              res_done_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_data_next = ram_rdata;
        state_next    = ST_FINISH;
      end
      ST_COPY: begin
        // Reads run one byte ahead of the writes; the destination always lies
        // below every source still to be read, so the copy needs no interlock.
        if (rd_cnt != move_counter) begin
          ram_re       = 1'b1;
          ram_raddr    = src_idx[ADDR_W-1:0];
          rd_cnt_next  = rd_cnt + CNT_W'(1);
          wr_pend_next = 1'b1;
          wr_addr_next = rd_cnt[ADDR_W-1:0];
        end
        if (wr_pend) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr;
          ram_wdata = ram_rdata;
        end
        if (rd_cnt == move_counter && !wr_pend) begin
          rd_idx_next = '0;
          wr_idx_next = move_counter;
          state_next  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // The read index never passes the write index.
  assert property (@(posedge clk) disable iff (rst) rd_idx <= wr_idx)
    else $error("read index above write index");

  // The write index stays within the store.
  assert property (@(posedge clk) disable iff (rst) wr_idx <= DEPTH_C)
    else $error("write index beyond the store");

  // A pending compaction write always targets a byte inside the moved run.
  assert property (@(posedge clk) disable iff (rst)
      wr_pend |-> (state == ST_COPY && CNT_W'(wr_addr) < move_counter))
    else $error("compaction write outside the moved run");

  // Clear empties the buffer in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
      (in_valid && in_ready && in_data.kind == KIND_CLEAR)
      |=> (rd_idx == '0 && wr_idx == '0))
    else $error("clear did not empty the buffer");

endmodule
